[hw/rtl/sha_pkg.sv]
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  // one classified transaction from front to back
  typedef struct packed {
    word_t      data;
    logic [2:0] nbytes;
    logic       last;
  } item_t;

  localparam int unsigned QueueDepth = 2;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_FILL, ST_PAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_e;

  function automatic word_t rotr(word_t v, int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sha_front.sv]
`default_nettype none
// Input stage: clamps the byte count and buffers transactions in a short queue.
module sha_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             stall_o,
  input  wire [31:0]       message_word_i,
  input  wire [2:0]        byte_count_i,
  input  wire              last_word_i,
  output logic             q_valid_o,
  input  wire              q_pop_i,
  output sha_pkg::item_t   q_item_o
);
  import sha_pkg::*;

  item_t      mem_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QueueDepth):0]   cnt_q;
  item_t      in_item;
  logic       push, pop;

  always_comb begin
    in_item.data = message_word_i;
    in_item.last = last_word_i;
    if (!last_word_i || byte_count_i > 3'd4) in_item.nbytes = 3'd4;
    else in_item.nbytes = byte_count_i;
  end

  assign stall_o   = (cnt_q == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{$clog2(QueueDepth){1'b0}}, push} - {{$clog2(QueueDepth){1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sha_back.sv]
`default_nettype none
// Block packing, padding, one compression round per cycle, digest output.
module sha_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             q_valid_i,
  output logic            q_pop_o,
  input  sha_pkg::item_t  q_item_i,
  output logic            valid_o,
  input  wire             stall_i,
  output logic [31:0]     digest_word_o,
  output logic [2:0]      word_index_o,
  output logic            last_result_o
);
  import sha_pkg::*;

  state_e     state_q, state_d;
  word_t      h_q [8];
  word_t      r_q [8];
  word_t      w_q [16];
  logic [3:0] fill_q;
  logic [5:0] rnd_q;
  logic [63:0] bytes_q;
  logic       final_q;   // the message's 0x80 pad byte has been placed
  logic       lenblk_q;  // padding needs a further block after this one
  logic [2:0] oidx_q;

  // padding word built from the last transaction
  word_t      pad_word;
  logic [63:0] bytes_sum, bits;
  word_t      mask;
  // round datapath
  word_t      wn, wcur, s0, s1, t1, t2, e, a;

  always_comb begin
    unique case (q_item_i.nbytes)
      3'd0: mask = 32'h0000_0000;
      3'd1: mask = 32'hff00_0000;
      3'd2: mask = 32'hffff_0000;
      3'd3: mask = 32'hffff_ff00;
      default: mask = 32'hffff_ffff;
    endcase
    pad_word  = (q_item_i.data & mask) | (32'h8000_0000 >> {q_item_i.nbytes, 3'b000});
    bytes_sum = bytes_q + {61'd0, q_item_i.nbytes};
    bits      = {bytes_q[60:0], 3'b000};
  end

  always_comb begin
    wcur = w_q[0];
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    e  = r_q[4];
    a  = r_q[0];
    t1 = r_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & r_q[5]) ^ (~e & r_q[6])) + RoundK[rnd_q] + wcur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & r_q[1]) ^ (a & r_q[2]) ^ (r_q[1] & r_q[2]));
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_FILL:  begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (!q_item_i.last || q_item_i.nbytes == 3'd4) begin
            if (fill_q == 4'd15) state_d = ST_ROUND;
            else if (q_item_i.last) state_d = ST_PAD;
          end else begin
            state_d = ST_PAD;
            if (fill_q == 4'd15) state_d = ST_ROUND;
          end
        end
      end
      ST_PAD:   if (fill_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD:  begin
        if (lenblk_q) state_d = ST_PAD;
        else if (final_q) state_d = ST_EMIT;
        else state_d = ST_FILL;
      end
      ST_EMIT:  if (!stall_i && oidx_q == 3'd7) state_d = ST_FILL;
      default:  state_d = ST_FILL;
    endcase
  end

  assign valid_o       = (state_q == ST_EMIT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_result_o = (oidx_q == 3'd7);

  // w_q acts as a shift line: fill words are written by index, rounds shift it down and enter the new word at the top
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL && q_valid_i) begin
      if (!q_item_i.last || q_item_i.nbytes == 3'd4) w_q[fill_q] <= q_item_i.data;
      else w_q[fill_q] <= pad_word;
    end else if (state_q == ST_PAD) begin
      // final_q low: a full last word still owes the 0x80 word
      if (!final_q) w_q[fill_q] <= 32'h8000_0000;
      else if (fill_q == 4'd14 && !lenblk_q) w_q[fill_q] <= bits[63:32];
      else if (fill_q == 4'd15 && !lenblk_q) w_q[fill_q] <= bits[31:0];
      else w_q[fill_q] <= 32'h0;
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= e;
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= a;
      r_q[0] <= t1 + t2;
    end else if (state_d == ST_ROUND) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      fill_q   <= '0;
      rnd_q    <= '0;
      bytes_q  <= '0;
      final_q  <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_FILL: if (q_valid_i) begin
          fill_q  <= fill_q + 4'd1;
          bytes_q <= bytes_sum;
          if (q_item_i.last) begin
            // a full last word leaves the 0x80 byte to the pad state (final_q low there);
            // from word 14 on, the length cannot share the block
            final_q  <= (q_item_i.nbytes != 3'd4);
            lenblk_q <= (fill_q >= 4'd14);
          end
        end
        ST_PAD: begin
          fill_q <= fill_q + 4'd1;
          if (!final_q) begin
            // 0x80 word just placed; now in the normal padding run
            final_q <= 1'b1;
            if (fill_q >= 4'd14) lenblk_q <= 1'b1;
          end
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
          if (lenblk_q) begin
            lenblk_q <= 1'b0;
          end
        end
        ST_EMIT: if (!stall_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
            bytes_q <= '0;
            final_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sha256_stream_hasher.sv]
`default_nettype none
// SHA-256 over a stream of big-endian 32-bit words. Each input transaction is one
// word; a word with last_word_i set may carry 0 to 4 bytes, and counts above four are
// taken as four. Each 16-word block takes 16 fill transactions, then compression (one
// round per cycle in the single round unit) and a chaining add. After the last word
// the block pads internally (with one extra compressed block when the 0x80 byte
// lands in word 14 or 15), then presents eight digest transactions, word_index_o 0
// first, last_result_o on the eighth, and resets the chaining words for the next
// message. A two-entry queue lets input transactions land while the core compresses
// or waits on a stalled output.
module sha256_stream_hasher (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         valid_i,
  output logic        stall_o,
  input  wire [31:0]  message_word_i,
  input  wire [2:0]   byte_count_i,
  input  wire         last_word_i,
  output logic        valid_o,
  input  wire         stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_result_o
);
  import sha_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop;

  sha_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .message_word_i, .byte_count_i, .last_word_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_result_o
  );
endmodule
`default_nettype wire

[verif/tb_sha256_stream_hasher.sv]
`default_nettype none
module tb_sha256_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  // One expected digest word with its index and last flag
  typedef struct {
    word_t       digest;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Scoreboard: tracks the running hash state and holds pending digest words
  class sha256_scoreboard;
    word_t          chain [8];
    word_t          blk [16];
    int unsigned    fill;
    logic [63:0]    nbytes;
    digest_beat_t   pending [$];
    int unsigned    errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = InitH[i];
      fill = 0;
      nbytes = '0;
    endfunction

    static function word_t ror(word_t v, int unsigned s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress();
      word_t w [64];
      word_t r [8];
      word_t s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      r = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
        t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
    endfunction

    function void push_word(word_t x);
      blk[fill] = x;
      fill = (fill + 1) % 16;
      if (fill == 0) compress();
    endfunction

    // Note one accepted input transaction
    function void note_word(word_t data, logic [2:0] cnt, logic lst);
      int unsigned n;
      logic [63:0] bitlen;
      word_t mask;
      digest_beat_t b;
      if (!lst) begin
        push_word(data);
        nbytes += 4;
        return;
      end
      n = (cnt > 4) ? 4 : cnt;
      nbytes += n;
      if (n == 4) begin
        push_word(data);
        push_word(32'h8000_0000);
      end else begin
        mask = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
        push_word((data & mask) | (32'h8000_0000 >> (8 * n)));
      end
      // 0x80 landed in word 14: length needs an extra block (after word 15, fill has already wrapped)
      if (fill > 14) while (fill != 0) push_word('0);
      while (fill < 14) push_word('0);
      bitlen = nbytes << 3;
      push_word(bitlen[63:32]);
      push_word(bitlen[31:0]);
      for (int i = 0; i < 8; i++) begin
        b.digest = chain[i];
        b.index = 3'(i);
        b.last = (i == 7);
        pending.push_back(b);
      end
      restart();
    endfunction

    task check_digest(word_t d, logic [2:0] idx, logic lst);
      digest_beat_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h idx %0d", d, idx));
        return;
      end
      e = pending.pop_front();
      if (d !== e.digest)
        report_mismatch($sformatf("digest word %h, want %h", d, e.digest));
      if (idx !== e.index)
        report_mismatch($sformatf("word_index %0d, want %0d", idx, e.index));
      if (lst !== e.last)
        report_mismatch($sformatf("last_result %b, want %b", lst, e.last));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] message_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_word_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_result_o;

  sha256_scoreboard sb = new();

  // Idle shaping: percentages of idle cycles per side; zero for clean stretches
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 33;
  int unsigned hold_cycles = 0;   // long receiver hold-off, counted down below
  bit          stim_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sha256_stream_hasher u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .message_word_i, .byte_count_i,
    .last_word_i, .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_result_o
  );

  // Receiver: stall decided at the falling edge, digest checked at the rising edge
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      sb.check_digest(digest_word_o, word_index_o, last_result_o);
  end

  // Offer one transaction and hold it until the block takes it
  task automatic send_word(word_t data, logic [2:0] cnt, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    message_word_i <= data;
    byte_count_i <= cnt;
    last_word_i <= lst;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_word(data, cnt, lst);
    // valid_i stays high until the next call idles or wait_drained drops it
    @(negedge clk_i);
  endtask

  // A message of nfull whole words, then a last word of cnt bytes
  task automatic send_message(int unsigned nfull, logic [2:0] cnt);
    for (int i = 0; i < nfull; i++)
      send_word($urandom(), 3'($urandom_range(7)), 1'b0);
    send_word($urandom(), cnt, 1'b1);
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  int unsigned sent;

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: an empty message, extreme words, byte counts 0 to 5 and 7
    send_word('0, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd5, 1'b1);
    // 0x80 in word 14, after a full and after a partial last word: extra length block
    send_message(13, 3'd4);
    send_message(14, 3'd2);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    hold_cycles = 600;
    send_message(20, 3'd3);
    send_message(3, 3'd6);
    wait_drained();

    // Clean stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent = 0;
    while (sent < 80) begin
      int unsigned n;
      n = $urandom_range(19);
      send_message(n, 3'($urandom_range(7)));
      sent += n + 1;
    end
    send_idle_pct = 33;
    recv_idle_pct = 33;

    // Random: mostly short messages, a few spanning several blocks
    sent = 0;
    while (sent < 330) begin
      int unsigned n;
      n = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(17);
      send_message(n, 3'($urandom_range(7)));
      sent += n + 1;
      if ($urandom_range(15) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(negedge clk_i);
    stim_done = 1'b1;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_sha256_stream_hasher: PASS");
    end else begin
      $display("tb_sha256_stream_hasher: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12ms;
    if (!stim_done) $display("tb_sha256_stream_hasher: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_back.sv
hw/rtl/sha256_stream_hasher.sv
verif/tb_sha256_stream_hasher.sv
